>>> rtl/dswb_pkg.sv
// Shared types and constants for the dirty sector write-back tracker.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package dswb_pkg;

    localparam int SECTORS      = 512;
    localparam int SECTOR_BYTES = 4096;
    localparam int BLOCK_BYTES  = 512;

    localparam int FIELD_W   = 16;
    localparam int DISK_W    = 22;
    localparam int FADDR_W   = 21;
    localparam int CFG_IDX_W = 1;

    localparam int SECT_SH   = $clog2(SECTOR_BYTES);
    localparam int BLK_SH    = $clog2(BLOCK_BYTES);
    localparam int ADDR_W    = FIELD_W + BLK_SH + 1;
    localparam int SIDX_W    = ADDR_W - SECT_SH;
    localparam int SEC_IDX_W = $clog2(SECTORS);
    localparam int TOT_W     = SEC_IDX_W + 1;

    localparam int ROW_BITS  = 32;
    localparam int ROW_LSB   = $clog2(ROW_BITS);
    localparam int ROWS      = SECTORS / ROW_BITS;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_BYTES    = 1'd1;

    localparam logic [DISK_W-1:0] DISK_BYTES_RESET = DISK_W'(2097152);

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_FLUSH = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [FIELD_W-1:0]   block_number;
        logic [FIELD_W-1:0]   byte_offset;
        logic [FIELD_W-1:0]   length;
    } t_in_word;

    typedef struct packed {
        logic                 status;
        logic [FIELD_W-1:0]   byte_count;
        logic                 flush_found;
        logic [SEC_IDX_W-1:0] flush_sector;
        logic [FADDR_W-1:0]   flush_address;
    } t_out_word;

    typedef struct packed {
        logic                 mirror_enable;
        logic [DISK_W-1:0]    disk_bytes;
    } t_cfg;

    typedef logic [ROW_BITS-1:0] t_row;

    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic                 clear_all;
        logic [ROW_W-1:0]     row;
        t_row                 wr_data;
    } t_map_req;

endpackage

>>> rtl/dswb_map_ram.sv
// Dirty map storage: a row-organized synchronous RAM with per-row valid bits.
// Depends on dswb_pkg for row geometry and the request struct.
`timescale 1ns / 1ps

module dswb_map_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dswb_pkg::t_map_req i_req,
    output dswb_pkg::t_row    o_rdata
);

    dswb_pkg::t_row                  r_mem [dswb_pkg::ROWS];
    dswb_pkg::t_row                  r_rdata;
    logic                            r_rd_ok;
    logic [dswb_pkg::ROWS-1:0]       r_row_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.row] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.row];
        end
    end

    // A row that was never written since the last clear reads as all clean.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_ok <= r_row_valid[i_req.row];
            end
            if (i_req.clear_all) begin
                r_row_valid <= '0;
            end else if (i_req.wr_en) begin
                r_row_valid[i_req.row] <= 1'b1;
            end
        end
    end

    assign o_rdata = r_rd_ok ? r_rdata : '0;

endmodule

>>> rtl/dswb_seq.sv
// Access sequencer: bounds check, range marking and first-dirty search.
// Depends on dswb_pkg; drives the dswb_map_ram request port.
`timescale 1ns / 1ps

module dswb_seq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dswb_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    input  dswb_pkg::t_in_word   i_in_word,
    output logic                 o_in_ready,
    output logic                 o_res_valid,
    output dswb_pkg::t_out_word  o_res,
    input  logic                 i_res_ready,
    output dswb_pkg::t_map_req   o_map_req,
    input  dswb_pkg::t_row       i_map_rdata
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_READ  = 5'b00100,
        S_MOD   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                            r_state;
    dswb_pkg::t_action                 r_act;
    logic [dswb_pkg::ADDR_W-1:0]       r_addr;
    logic [dswb_pkg::FIELD_W-1:0]      r_len;
    logic [dswb_pkg::FIELD_W-1:0]      r_lenm1;
    logic [dswb_pkg::SIDX_W-1:0]       r_first;
    logic [dswb_pkg::SIDX_W-1:0]       r_last;
    logic [dswb_pkg::ROW_W-1:0]        r_row;
    dswb_pkg::t_out_word               r_res;

    logic [dswb_pkg::TOT_W-1:0]        w_dsec;
    logic [dswb_pkg::TOT_W-1:0]        w_total;
    logic [dswb_pkg::ADDR_W:0]         w_end;
    logic [dswb_pkg::ADDR_W-1:0]       w_endm1;
    logic                              w_over;
    logic [dswb_pkg::SIDX_W-1:0]       w_first;
    logic [dswb_pkg::SIDX_W-1:0]       w_last;
    logic                              w_first_in;

    logic [dswb_pkg::SEC_IDX_W-1:0]    w_sec;
    dswb_pkg::t_row                    w_in_total;
    dswb_pkg::t_row                    w_in_range;
    dswb_pkg::t_row                    w_cand;
    dswb_pkg::t_row                    w_hit_mask;
    logic [dswb_pkg::ROW_LSB-1:0]      w_hit_idx;
    logic                              w_hit;
    logic [dswb_pkg::ROW_W:0]          w_row_inc;
    logic [dswb_pkg::TOT_W-1:0]        w_next_start;
    logic                              w_past_total;
    logic                              w_row_covers_last;
    logic [dswb_pkg::SEC_IDX_W-1:0]    w_hit_sector;

    // Active sector count, capped at the map size.
    assign w_dsec  = dswb_pkg::TOT_W'(i_cfg.disk_bytes[dswb_pkg::DISK_W-1:dswb_pkg::SECT_SH]);
    assign w_total = (w_dsec > dswb_pkg::TOT_W'(dswb_pkg::SECTORS))
                   ? dswb_pkg::TOT_W'(dswb_pkg::SECTORS) : w_dsec;

    assign w_end      = {1'b0, r_addr} + (dswb_pkg::ADDR_W + 1)'(r_len);
    assign w_endm1    = r_addr + dswb_pkg::ADDR_W'(r_lenm1);
    assign w_over     = w_end > (dswb_pkg::ADDR_W + 1)'(i_cfg.disk_bytes);
    assign w_first    = r_addr[dswb_pkg::ADDR_W-1:dswb_pkg::SECT_SH];
    assign w_last     = w_endm1[dswb_pkg::ADDR_W-1:dswb_pkg::SECT_SH];
    assign w_first_in = w_first < dswb_pkg::SIDX_W'(w_total);

    always_comb begin
        w_sec      = '0;
        w_in_total = '0;
        w_in_range = '0;
        for (int b = 0; b < dswb_pkg::ROW_BITS; b++) begin
            w_sec         = {r_row, dswb_pkg::ROW_LSB'(b)};
            w_in_total[b] = {1'b0, w_sec} < w_total;
            w_in_range[b] = (dswb_pkg::SIDX_W'(w_sec) >= r_first)
                         && (dswb_pkg::SIDX_W'(w_sec) <= r_last);
        end
    end

    assign w_cand = i_map_rdata & w_in_total;
    assign w_hit  = |w_cand;

    always_comb begin
        w_hit_idx = '0;
        for (int b = dswb_pkg::ROW_BITS - 1; b >= 0; b--) begin
            if (w_cand[b]) begin
                w_hit_idx = dswb_pkg::ROW_LSB'(b);
            end
        end
    end

    always_comb begin
        w_hit_mask            = '0;
        w_hit_mask[w_hit_idx] = 1'b1;
    end

    assign w_hit_sector      = {r_row, w_hit_idx};
    assign w_row_inc         = {1'b0, r_row} + (dswb_pkg::ROW_W + 1)'(1);
    assign w_next_start      = {w_row_inc, {dswb_pkg::ROW_LSB{1'b0}}};
    assign w_past_total      = w_next_start >= w_total;
    assign w_row_covers_last =
        dswb_pkg::SIDX_W'({r_row, {dswb_pkg::ROW_LSB{1'b1}}}) >= r_last;

    always_comb begin
        o_map_req           = '0;
        o_map_req.row       = r_row;
        o_map_req.rd_en     = (r_state == S_READ);
        o_map_req.clear_all = (r_state == S_CHECK) && (r_act == dswb_pkg::ACT_CLEAR)
                            && i_cfg.mirror_enable;
        if (r_state == S_MOD) begin
            if (r_act == dswb_pkg::ACT_WRITE) begin
                o_map_req.wr_en   = 1'b1;
                o_map_req.wr_data = i_map_rdata | (w_in_total & w_in_range);
            end else begin
                o_map_req.wr_en   = w_hit;
                o_map_req.wr_data = i_map_rdata & ~w_hit_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_act   <= i_in_word.action;
                        r_addr  <= {1'b0, i_in_word.block_number, {dswb_pkg::BLK_SH{1'b0}}}
                                 + dswb_pkg::ADDR_W'(i_in_word.byte_offset);
                        r_len   <= i_in_word.length;
                        r_lenm1 <= i_in_word.length - dswb_pkg::FIELD_W'(1);
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_res   <= '0;
                    r_first <= w_first;
                    r_last  <= w_last;
                    r_row   <= '0;
                    r_state <= S_DONE;
                    case (r_act)
                        dswb_pkg::ACT_WRITE: begin
                            if (!i_cfg.mirror_enable || w_over) begin
                                r_res.status <= 1'b1;
                            end else begin
                                r_res.byte_count <= r_len;
                                if ((r_len != '0) && w_first_in) begin
                                    r_row   <= w_first[dswb_pkg::ROW_LSB +: dswb_pkg::ROW_W];
                                    r_state <= S_READ;
                                end
                            end
                        end
                        dswb_pkg::ACT_READ: begin
                            if (w_over) begin
                                r_res.status <= 1'b1;
                            end else begin
                                r_res.byte_count <= r_len;
                            end
                        end
                        dswb_pkg::ACT_FLUSH: begin
                            if (i_cfg.mirror_enable) begin
                                r_state <= S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_READ: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_act == dswb_pkg::ACT_WRITE) begin
                        if (w_row_covers_last || w_past_total) begin
                            r_state <= S_DONE;
                        end else begin
                            r_row   <= w_row_inc[dswb_pkg::ROW_W-1:0];
                            r_state <= S_READ;
                        end
                    end else if (w_hit) begin
                        r_res.flush_found   <= 1'b1;
                        r_res.flush_sector  <= w_hit_sector;
                        r_res.flush_address <= dswb_pkg::FADDR_W'({w_hit_sector,
                                               {dswb_pkg::SECT_SH{1'b0}}});
                        r_state <= S_DONE;
                    end else if (w_past_total) begin
                        r_state <= S_DONE;
                    end else begin
                        r_row   <= w_row_inc[dswb_pkg::ROW_W-1:0];
                        r_state <= S_READ;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

endmodule

>>> rtl/dirty_sector_write_back_tracker.sv
// Top level of the dirty sector write-back tracker: configuration registers,
// output register and assertions. Depends on dswb_pkg, dswb_seq and dswb_map_ram.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake                 Payload
//  input     in         i_in_valid / o_in_ready   i_in_word  (dswb_pkg::t_in_word)
//  output    out        o_out_valid / i_out_ready o_out_word (dswb_pkg::t_out_word)
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
//  One word is in work at a time. A read, a clear or a rejected write goes from
//  acceptance through a check state to a loaded result; a marking write also
//  visits up to two 32-sector rows, and a flush scans rows up to the first
//  dirty sector; each row is a read of the map RAM and a modify state that may
//  write it back. Reset is synchronous and active low; it clears the map through
//  per-row valid bits and loads the configuration defaults. A stalled output
//  holds the sequencer in its done state and so blocks the next word.

module dirty_sector_write_back_tracker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  dswb_pkg::t_in_word                   i_in_word,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output dswb_pkg::t_out_word                  o_out_word,
    input  logic                                 i_cfg_we,
    input  logic [dswb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [dswb_pkg::DISK_W-1:0]          i_cfg_data
);

    // Configuration registers; the user must write them only while the block is idle, which the block does not enforce.
    logic                              r_mirror_enable;
    logic [dswb_pkg::DISK_W-1:0]       r_disk_bytes;
    dswb_pkg::t_cfg                    w_cfg;

    // Output register that decouples the sequencer from the consumer.
    logic                              r_out_valid;
    dswb_pkg::t_out_word               r_out_word;

    logic                              w_res_valid;
    logic                              w_res_ready;
    dswb_pkg::t_out_word               w_res;
    dswb_pkg::t_map_req                w_map_req;
    dswb_pkg::t_row                    w_map_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirror_enable <= 1'b1;
            r_disk_bytes    <= dswb_pkg::DISK_BYTES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dswb_pkg::CFG_MIRROR_ENABLE: r_mirror_enable <= i_cfg_data[0];
                dswb_pkg::CFG_DISK_BYTES:    r_disk_bytes    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.mirror_enable = r_mirror_enable;
    assign w_cfg.disk_bytes    = r_disk_bytes;

    dswb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_ready  (o_in_ready),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_map_req   (w_map_req),
        .i_map_rdata (w_map_rdata)
    );

    dswb_map_ram u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_map_req),
        .o_rdata (w_map_rdata)
    );

    // The sequencer hands over its result whenever the output register is empty
    // or is being emptied in the same cycle.
    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // A word is worked on alone: right after acceptance the input side is closed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is in work");

    // The reported byte address always belongs to the reported sector.
    a_flush_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.flush_address
            == dswb_pkg::FADDR_W'({o_out_word.flush_sector,
                                    {dswb_pkg::SECT_SH{1'b0}}})))
        else $error("flush address does not match flush sector");

    // An error result carries no byte count and no flush report.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status)
            |-> (o_out_word.byte_count == '0) && !o_out_word.flush_found)
        else $error("error result carries payload");

endmodule

>>> sim/tb_dirty_sector_write_back_tracker.sv
// Self-checking testbench for the dirty sector write-back tracker: directed and random
// words checked against a behavioral tracker model kept inside the testbench.
// Depends on dswb_pkg and dirty_sector_write_back_tracker from the rtl folder.
`timescale 1ns / 1ps

module tb_dirty_sector_write_back_tracker;

    localparam int IDLE_PCT    = 38;
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_ready;
    dswb_pkg::t_in_word             i_in_word   = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    dswb_pkg::t_out_word            o_out_word;
    logic                           i_cfg_we    = 1'b0;
    logic [dswb_pkg::CFG_IDX_W-1:0] i_cfg_index = dswb_pkg::CFG_MIRROR_ENABLE;
    logic [dswb_pkg::DISK_W-1:0]    i_cfg_data  = '0;

    // Tracker model: one dirty bit per sector plus a copy of both registers.
    logic [dswb_pkg::SECTORS-1:0]   model_dirty      = '0;
    logic                           mirror_on        = 1'b1;
    logic [dswb_pkg::DISK_W-1:0]    model_disk_bytes = dswb_pkg::DISK_BYTES_RESET;

    dswb_pkg::t_in_word   pending_words[$];
    dswb_pkg::t_out_word  expected_results[$];
    dswb_pkg::t_out_word  want;
    bit                   no_idle       = 1'b0;
    int                   words_queued  = 0;
    int                   words_accepted = 0;
    int                   results_checked = 0;
    int                   sectors_flushed = 0;
    int                   settings_run  = 0;
    int                   error_count   = 0;
    int                   stall_cycles  = 0;

    dirty_sector_write_back_tracker uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Applies one accepted word to the model and returns the result it must produce.
    // The byte address is formed in 64 bits so that it never wraps.
    function automatic dswb_pkg::t_out_word track_word(input dswb_pkg::t_in_word w);
        dswb_pkg::t_out_word r;
        longint unsigned     addr;
        longint unsigned     last;
        longint unsigned     total;
        longint unsigned     s;
        r     = '0;
        addr  = w.block_number;
        addr  = addr * dswb_pkg::BLOCK_BYTES + w.byte_offset;
        total = model_disk_bytes / dswb_pkg::SECTOR_BYTES;
        if (total > dswb_pkg::SECTORS) begin
            total = dswb_pkg::SECTORS;
        end
        case (w.action)
            dswb_pkg::ACT_WRITE: begin
                if (!mirror_on || addr + w.length > model_disk_bytes) begin
                    r.status = 1'b1;
                end else begin
                    // Sectors past the active count are never marked.
                    if (w.length != 0) begin
                        last = (addr + w.length - 1) / dswb_pkg::SECTOR_BYTES;
                        for (s = addr / dswb_pkg::SECTOR_BYTES; s <= last && s < total;
                             s++) begin
                            model_dirty[s] = 1'b1;
                        end
                    end
                    r.byte_count = w.length;
                end
            end
            dswb_pkg::ACT_READ: begin
                if (addr + w.length > model_disk_bytes) begin
                    r.status = 1'b1;
                end else begin
                    r.byte_count = w.length;
                end
            end
            dswb_pkg::ACT_FLUSH: begin
                if (mirror_on) begin
                    for (s = 0; s < total && !r.flush_found; s++) begin
                        if (model_dirty[s]) begin
                            model_dirty[s]  = 1'b0;
                            r.flush_found   = 1'b1;
                            r.flush_sector  = dswb_pkg::SEC_IDX_W'(s);
                            r.flush_address = dswb_pkg::FADDR_W'(s * dswb_pkg::SECTOR_BYTES);
                        end
                    end
                end
            end
            dswb_pkg::ACT_CLEAR: begin
                if (mirror_on) begin
                    model_dirty = '0;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic queue_word(input dswb_pkg::t_action act, input int blk, input int off,
                              input int len);
        dswb_pkg::t_in_word w;
        w.action       = act;
        w.block_number = dswb_pkg::FIELD_W'(blk);
        w.byte_offset  = dswb_pkg::FIELD_W'(off);
        w.length       = dswb_pkg::FIELD_W'(len);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Mostly in-bounds reads and writes with random placement, some that end exactly at
    // or just past the disk end, flush ticks, a few clears and some fully random words.
    task automatic add_random_words(input int count);
        longint unsigned addr;
        longint unsigned len;
        int              pick;
        int              blk;
        int              off;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                len = ($urandom_range(9) < 7) ? $urandom_range(9000) : $urandom_range(65535);
                if (len > model_disk_bytes) begin
                    len = model_disk_bytes;
                end
                case ($urandom_range(9))
                    0:       addr = model_disk_bytes - len + 1 + $urandom_range(600);
                    1:       addr = model_disk_bytes - len;
                    default: addr = $urandom_range(model_disk_bytes - len);
                endcase
                // Split the address into block and offset in a random way.
                off = $urandom_range(addr < 65535 ? addr : 65535);
                blk = (addr - off) / dswb_pkg::BLOCK_BYTES;
                off = addr - longint'(blk) * dswb_pkg::BLOCK_BYTES;
                if (off > 65535) begin
                    off -= dswb_pkg::BLOCK_BYTES;
                    blk += 1;
                end
                queue_word((pick < 45) ? dswb_pkg::ACT_WRITE : dswb_pkg::ACT_READ,
                           blk, off, len);
            end else if (pick < 82) begin
                queue_word(dswb_pkg::ACT_FLUSH, $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535));
            end else if (pick < 85) begin
                queue_word(dswb_pkg::ACT_CLEAR, $urandom_range(65535), $urandom_range(65535),
                           $urandom_range(65535));
            end else begin
                queue_word(dswb_pkg::t_action'($urandom_range(3)), $urandom_range(65535),
                           $urandom_range(65535), $urandom_range(65535));
            end
        end
    endtask

    // Waits until every queued word has been accepted and answered.
    task automatic drain();
        do begin
            @(posedge i_clk);
        end while (words_accepted != words_queued || expected_results.size() != 0);
    endtask

    // Writes both registers while the block is idle, then runs random words under them.
    task automatic run_phase(input bit mirror, input int unsigned disk, input int count);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= dswb_pkg::CFG_MIRROR_ENABLE;
        i_cfg_data  <= dswb_pkg::DISK_W'(mirror);
        @(posedge i_clk);
        i_cfg_index <= dswb_pkg::CFG_DISK_BYTES;
        i_cfg_data  <= dswb_pkg::DISK_W'(disk);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mirror_on        = mirror;
        model_disk_bytes = dswb_pkg::DISK_W'(disk);
        settings_run++;
        add_random_words(count);
        drain();
    endtask

    // Sender: a new word is offered only when the previous one has gone.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                words_accepted++;
                expected_results.push_back(track_word(i_in_word));
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() != 0 &&
                    (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pending_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Receiver check: every result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_out_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_word.status);
                    error_count++;
                end
                if (o_out_word.byte_count !== want.byte_count) begin
                    $error("byte_count: expected %0d, got %0d",
                           want.byte_count, o_out_word.byte_count);
                    error_count++;
                end
                if (o_out_word.flush_found !== want.flush_found) begin
                    $error("flush_found: expected %0d, got %0d",
                           want.flush_found, o_out_word.flush_found);
                    error_count++;
                end
                if (o_out_word.flush_sector !== want.flush_sector) begin
                    $error("flush_sector: expected %0d, got %0d",
                           want.flush_sector, o_out_word.flush_sector);
                    error_count++;
                end
                if (o_out_word.flush_address !== want.flush_address) begin
                    $error("flush_address: expected %0d, got %0d",
                           want.flush_address, o_out_word.flush_address);
                    error_count++;
                end
                if (want.flush_found) begin
                    sectors_flushed++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves on any port for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("tb_dirty_sector_write_back_tracker failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: zero length, a write spanning two sectors, ranges ending
        // exactly at and one byte past the disk end, all-ones fields, flush on an
        // empty map, and clear.
        queue_word(dswb_pkg::ACT_WRITE, 0, 0, 0);
        queue_word(dswb_pkg::ACT_FLUSH, 0, 0, 0);
        queue_word(dswb_pkg::ACT_WRITE, 0, 0, 1);
        queue_word(dswb_pkg::ACT_WRITE, 7, 500, 200);
        queue_word(dswb_pkg::ACT_WRITE, 4095, 0, 512);
        queue_word(dswb_pkg::ACT_WRITE, 4095, 0, 513);
        queue_word(dswb_pkg::ACT_WRITE, 65535, 65535, 65535);
        queue_word(dswb_pkg::ACT_READ, 65535, 65535, 65535);
        queue_word(dswb_pkg::ACT_READ, 0, 0, 65535);
        queue_word(dswb_pkg::ACT_READ, 4096, 0, 0);
        queue_word(dswb_pkg::ACT_WRITE, 0, 65535, 65535);
        queue_word(dswb_pkg::ACT_FLUSH, 0, 0, 0);
        queue_word(dswb_pkg::ACT_FLUSH, 65535, 65535, 65535);
        queue_word(dswb_pkg::ACT_FLUSH, 0, 0, 0);
        queue_word(dswb_pkg::ACT_CLEAR, 65535, 65535, 65535);
        queue_word(dswb_pkg::ACT_FLUSH, 0, 0, 0);
        queue_word(dswb_pkg::ACT_WRITE, 100, 0, 1);
        drain();

        // Mirror off: writes fail, reads only check bounds, flush and clear do nothing.
        run_phase(1'b0, 2097152, 0);
        queue_word(dswb_pkg::ACT_WRITE, 0, 0, 1);
        queue_word(dswb_pkg::ACT_READ, 0, 0, 100);
        queue_word(dswb_pkg::ACT_FLUSH, 0, 0, 0);
        queue_word(dswb_pkg::ACT_CLEAR, 0, 0, 0);
        drain();

        // One active sector: a write into the partial second sector marks nothing,
        // and a dirty sector above the active count stays hidden until the disk grows.
        run_phase(1'b1, 6000, 0);
        queue_word(dswb_pkg::ACT_WRITE, 0, 5000, 100);
        queue_word(dswb_pkg::ACT_FLUSH, 0, 0, 0);
        drain();
        run_phase(1'b1, 2097152, 0);
        queue_word(dswb_pkg::ACT_FLUSH, 0, 0, 0);
        queue_word(dswb_pkg::ACT_FLUSH, 0, 0, 0);
        drain();

        run_phase(1'b1, 2097152, 150);
        no_idle = 1'b1;
        run_phase(1'b1, 65536, 80);
        no_idle = 1'b0;
        run_phase(1'b0, $urandom_range(2097152), 40);
        run_phase(1'b1, 0, 20);
        run_phase(1'b1, 4095, 20);
        run_phase(1'b1, 4096, 40);
        run_phase(1'b1, $urandom_range(2097151, 4097), 100);
        run_phase(1'b1, 4194303, 80);
        run_phase(1'b1, 2097152, 70);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results for %0d words under %0d register settings.",
                 results_checked, words_accepted, settings_run);
        $display("Flush ticks wrote back %0d sectors; %0d mismatches seen.",
                 sectors_flushed, error_count);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_dirty_sector_write_back_tracker passed");
        end else begin
            $display("tb_dirty_sector_write_back_tracker failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/dswb_pkg.sv
rtl/dswb_map_ram.sv
rtl/dswb_seq.sv
rtl/dirty_sector_write_back_tracker.sv
sim/tb_dirty_sector_write_back_tracker.sv
